// File: src/cdate_pkg.sv
package cdate_pkg;

  localparam int STEP_BITS_DEF = 10;

  localparam logic [3:0]  RESET_MONTH = 4'd1;
  localparam logic [4:0]  RESET_DAY   = 5'd1;
  localparam logic [15:0] RESET_YEAR  = 16'd2000;

  // year / 25 by reciprocal: q = (year * Y25_MUL) >> Y25_SHIFT, exact for 16-bit years
  localparam logic [16:0] Y25_MUL   = 17'd83887;
  localparam int          Y25_SHIFT = 21;
  localparam int          Q_BITS    = 12;
  localparam logic [Q_BITS-1:0] RESET_Q = Q_BITS'(2000 / 25);

  localparam logic [8:0] DAYS_LEAP   = 9'd366;
  localparam logic [8:0] DAYS_COMMON = 9'd365;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef logic [2:0] upc_t;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADV,
    OP_LOAD,
    OP_FINISH
  } op_t;

  typedef enum logic [1:0] {
    C_NEVER,
    C_ALWAYS,
    C_IS_LOAD,
    C_ADV_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic is_load;
    logic adv_more;
  } flags_t;

  localparam upc_t A_DISPATCH  = 3'd0;
  localparam upc_t A_ADV       = 3'd1;
  localparam upc_t A_ADV_END   = 3'd2;
  localparam upc_t A_LD_WAIT   = 3'd3;
  localparam upc_t A_LD_CHECK  = 3'd4;
  localparam upc_t A_LD_SETTLE = 3'd5;
  localparam upc_t A_FINISH    = 3'd6;

  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    case (a)
      A_DISPATCH:  w = '{op: OP_NOP,    cond: C_IS_LOAD,  target: A_LD_WAIT};
      A_ADV:       w = '{op: OP_ADV,    cond: C_ADV_MORE, target: A_ADV};
      A_ADV_END:   w = '{op: OP_NOP,    cond: C_ALWAYS,   target: A_FINISH};
      A_LD_WAIT:   w = '{op: OP_NOP,    cond: C_NEVER,    target: A_DISPATCH};
      A_LD_CHECK:  w = '{op: OP_LOAD,   cond: C_NEVER,    target: A_DISPATCH};
      A_LD_SETTLE: w = '{op: OP_NOP,    cond: C_NEVER,    target: A_DISPATCH};
      A_FINISH:    w = '{op: OP_FINISH, cond: C_ALWAYS,   target: A_DISPATCH};
      default:     w = '{op: OP_NOP,    cond: C_ALWAYS,   target: A_DISPATCH};
    endcase
    return w;
  endfunction

  // leap from the year and its registered quotient by 25
  function automatic logic is_leap(input logic [15:0] year, input logic [Q_BITS-1:0] q);
    logic [15:0] q25;
    logic        div25;
    q25   = 16'({q, 4'b0000}) + 16'({q, 3'b000}) + 16'(q);
    div25 = (q25 == year);
    return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: src/cdate_useq.sv
module cdate_useq (
  input  logic             clk,
  input  logic             rst,
  input  logic             run,
  input  cdate_pkg::flags_t flags,
  output cdate_pkg::uword_t uword
);
  import cdate_pkg::*;

  upc_t pc;
  upc_t pc_next;
  logic take;

  always_comb begin
    uword = ucode(pc);
    case (uword.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_IS_LOAD:  take = flags.is_load;
      C_ADV_MORE: take = flags.adv_more;
      default:    take = 1'b0;
    endcase
    if (!run) begin
      pc_next = A_DISPATCH;
    end else if (take) begin
      pc_next = uword.target;
    end else begin
      pc_next = pc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_DISPATCH;
    end else begin
      pc <= pc_next;
    end
  end

  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= A_FINISH)
    else $error("step counter left the program");

  a_idle_home: assert property (@(posedge clk) disable iff (rst) !run |=> pc == A_DISPATCH)
    else $error("step counter not parked while idle");

  a_adv_entry: assert property (@(posedge clk) disable iff (rst)
      (pc == A_ADV) |-> ($past(pc) == A_DISPATCH || $past(pc) == A_ADV))
    else $error("advance step entered from a wrong step");

endmodule

// File: src/calendar_date_advance_core.sv
// Gregorian date keeper. Pulse start with busy low to hand in one word:
// func 1 loads load_month/load_day/load_year (rejected with status 1 when the
// date is invalid, state unchanged), func 0 advances the stored date by
// day_step days (zero allowed). Every word yields exactly one result on
// cur_month, cur_day, cur_year, leap_flag, day_of_year, days_remaining and
// status, shown for one cycle with done high; the receiver cannot stall.
// Control is a microprogram of seven steps run by a step counter.
// Steps while busy: a load runs dispatch, wait, check, settle and finish; an
// advance runs dispatch, then advance steps (one per month end crossed, plus
// one that stays inside a month unless the last crossing uses up the count,
// so at least one), then an end step and finish.
// done rises at the edge where busy falls, so it is high in the first idle
// cycle, and a new word may be accepted in that same cycle; while busy no
// new word is taken. The leap test uses a registered multiply by the
// reciprocal of 25, so its quotient trails the year it tests by a register:
// a load has a wait step before its check and a settle step after it; an
// advance needs the leap bit only in February, never right after a year change.
// Reset (rst, synchronous) sets the date to January 1, 2000, clears busy and
// done, and needs no clearing pass.
module calendar_date_advance_core #(
  parameter int STEP_BITS = cdate_pkg::STEP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 func,
  input  logic [3:0]           load_month,
  input  logic [4:0]           load_day,
  input  logic [15:0]          load_year,
  input  logic [STEP_BITS-1:0] day_step,
  output logic                 done,
  output logic [3:0]           cur_month,
  output logic [4:0]           cur_day,
  output logic [15:0]          cur_year,
  output logic                 leap_flag,
  output logic [8:0]           day_of_year,
  output logic [8:0]           days_remaining,
  output logic                 status
);
  import cdate_pkg::*;

  localparam int CW = (STEP_BITS > 6) ? STEP_BITS : 6;

  logic [3:0]           month;
  logic [4:0]           day;
  logic [15:0]          year;
  logic [STEP_BITS-1:0] n;
  logic                 func_r;
  logic [3:0]           lm_r;
  logic [4:0]           ld_r;
  logic [15:0]          ly_r;
  logic                 bad;
  logic [Q_BITS-1:0]    q;

  logic [15:0] yr_src;
  logic [32:0] prod;
  logic        leap;
  logic [4:0]  len;
  logic [4:0]  left;
  logic [CW-1:0] n_ext;
  logic [CW-1:0] left_ext;
  logic [CW-1:0] left1_ext;
  logic        fits;
  logic        ld_bad;
  logic [8:0]  doy;
  logic [8:0]  ylen;
  logic        accept;
  flags_t      flags;
  uword_t      uword;

  assign accept = start && !busy;

  // leap unit: operand is the year the current word is working on
  assign yr_src = (func_r && !bad) ? ly_r : year;
  assign prod   = 33'(yr_src) * 33'(Y25_MUL);
  assign leap   = is_leap(yr_src, q);

  always_comb begin
    len       = month_len(month, leap);
    left      = (len > day) ? (len - day) : 5'd0;
    n_ext     = CW'(n);
    left_ext  = CW'(left);
    left1_ext = CW'(left) + CW'(1);
    fits      = (n_ext <= left_ext);
    ld_bad    = (month_len(lm_r, leap) == 5'd0) || (ld_r == 5'd0)
                || (ld_r > month_len(lm_r, leap));
    doy       = 9'(day) + days_before(month)
                + 9'(leap && (month > MONTH_FEB));
    ylen      = leap ? DAYS_LEAP : DAYS_COMMON;
    flags.is_load  = func_r;
    flags.adv_more = (n_ext > left1_ext);
  end

  cdate_useq u_seq (
    .clk   (clk),
    .rst   (rst),
    .run   (busy),
    .flags (flags),
    .uword (uword)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      month <= RESET_MONTH;
      day   <= RESET_DAY;
      year  <= RESET_YEAR;
      q     <= RESET_Q;
      busy  <= 1'b0;
      done  <= 1'b0;
      bad   <= 1'b0;
    end else begin
      q    <= prod[32:Y25_SHIFT];
      done <= 1'b0;
      if (accept) begin
        busy   <= 1'b1;
        bad    <= 1'b0;
        func_r <= func;
        lm_r   <= load_month;
        ld_r   <= load_day;
        ly_r   <= load_year;
        n      <= day_step;
      end else if (busy) begin
        case (uword.op)
          OP_ADV: begin
            if (fits) begin
              day <= day + 5'(n_ext);
              n   <= '0;
            end else begin
              // roll into the first of the next month
              n   <= STEP_BITS'(n_ext - left1_ext);
              day <= RESET_DAY;
              if (month == MONTH_DEC) begin
                month <= MONTH_JAN;
                year  <= year + 16'd1;
              end else begin
                month <= month + 4'd1;
              end
            end
          end
          OP_LOAD: begin
            if (ld_bad) begin
              bad <= 1'b1;
            end else begin
              month <= lm_r;
              day   <= ld_r;
              year  <= ly_r;
            end
          end
          OP_FINISH: begin
            busy           <= 1'b0;
            done           <= 1'b1;
            cur_month      <= month;
            cur_day        <= day;
            cur_year       <= year;
            leap_flag      <= leap;
            day_of_year    <= doy;
            days_remaining <= (ylen >= doy) ? (ylen - doy) : 9'd0;
            status         <= bad;
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word shown while still busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result word without a word in flight");

  a_date_sane: assert property (@(posedge clk) disable iff (rst)
      done |-> (cur_day != 5'd0 && cur_month != 4'd0 && cur_month <= MONTH_DEC))
    else $error("reported date out of range");

endmodule
